// ----- rtl/oqs_pkg.sv -----
// ----------------------------------------------------------------------------
// oqs_pkg: shared types and constants
// Store depth, index widths and the request structs that the sequencer
// sends to the element and mark memories.
// ----------------------------------------------------------------------------
package oqs_pkg;

   localparam int DEPTH = 1024;
   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = IDX_W + 1;
   localparam int VAL_W = 32;

   localparam logic [1:0] OP_WRITE   = 2'd0;
   localparam logic [1:0] OP_PREPARE = 2'd1;
   localparam logic [1:0] OP_SELECT  = 2'd2;

   typedef struct packed {
      logic             we;
      logic [IDX_W-1:0] addr;
      logic [VAL_W-1:0] wdata;
   } elem_req_type;

   typedef struct packed {
      logic             we;
      logic [IDX_W-1:0] addr;
      logic             wdata;
   } mark_req_type;

   typedef struct packed {
      logic busy;
      logic prepared;
   } status_type;

endpackage

// ----- rtl/oqs_if.sv -----
// ----------------------------------------------------------------------------
// oqs_if: request and response channels
// Valid/ready channels; a transfer happens when valid and ready are both high.
// ----------------------------------------------------------------------------
interface oqs_req_if import oqs_pkg::*;;
   logic                    valid;
   logic                    ready;
   logic [1:0]              operation;
   logic [IDX_W-1:0]        slot_index;
   logic signed [VAL_W-1:0] element_value;

   modport source (output valid, operation, slot_index, element_value, input ready);
   modport sink   (input valid, operation, slot_index, element_value, output ready);
endinterface

interface oqs_rsp_if import oqs_pkg::*;;
   logic                    valid;
   logic                    ready;
   logic signed [VAL_W-1:0] selected_value;
   logic                    error;

   modport source (output valid, selected_value, error, input ready);
   modport sink   (input valid, selected_value, error, output ready);
endinterface

// ----- rtl/oqs_ram.sv -----
// ----------------------------------------------------------------------------
// oqs_ram: single-port memory
// One read or write per cycle, registered read data.
// ----------------------------------------------------------------------------
module oqs_ram #(
   parameter int WIDTH  = 32,
   parameter int ADDR_W = 10
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] addr,
   input  logic [WIDTH-1:0]  wdata,
   output logic [WIDTH-1:0]  rdata_ff
);

   logic [WIDTH-1:0] mem [2**ADDR_W];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

endmodule

// ----- rtl/oqs_core.sv -----
// ----------------------------------------------------------------------------
// oqs_core: sequencer with one shared signed comparator
// Runs writes, prepare scans and quickselect partitions over the element
// and mark memories, at most one access to each memory per cycle.
// ----------------------------------------------------------------------------
module oqs_core import oqs_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_we,
   input  logic [CNT_W-1:0] csr_wdata,
   oqs_req_if.sink          req_chan,
   oqs_rsp_if.source        rsp_chan,
   output elem_req_type     elem_req,
   input  logic [VAL_W-1:0] elem_rdata,
   output mark_req_type     mark_req,
   input  logic             mark_rdata,
   output status_type       status
);

   localparam logic [4:0] ST_IDLE    = 5'd0;
   localparam logic [4:0] ST_SCAN_RD = 5'd1;
   localparam logic [4:0] ST_SCAN_CK = 5'd2;
   localparam logic [4:0] ST_SCAN_HI = 5'd3;
   localparam logic [4:0] ST_PREP2   = 5'd4;
   localparam logic [4:0] ST_CLR     = 5'd5;
   localparam logic [4:0] ST_MARK0   = 5'd6;
   localparam logic [4:0] ST_MARKN   = 5'd7;
   localparam logic [4:0] ST_SW_RA   = 5'd8;
   localparam logic [4:0] ST_SW_RB   = 5'd9;
   localparam logic [4:0] ST_SW_WA   = 5'd10;
   localparam logic [4:0] ST_SW_WB   = 5'd11;
   localparam logic [4:0] ST_SEL_MRD = 5'd12;
   localparam logic [4:0] ST_SEL_MCK = 5'd13;
   localparam logic [4:0] ST_LSCAN   = 5'd14;
   localparam logic [4:0] ST_LCK     = 5'd15;
   localparam logic [4:0] ST_RSCAN   = 5'd16;
   localparam logic [4:0] ST_RCK     = 5'd17;
   localparam logic [4:0] ST_LOOP    = 5'd18;
   localparam logic [4:0] ST_PIV     = 5'd19;
   localparam logic [4:0] ST_PJ      = 5'd20;
   localparam logic [4:0] ST_PCK     = 5'd21;
   localparam logic [4:0] ST_PINC    = 5'd22;
   localparam logic [4:0] ST_PEND    = 5'd23;
   localparam logic [4:0] ST_SEL_VAL = 5'd24;
   localparam logic [4:0] ST_RESP    = 5'd25;

   localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);
   localparam logic [IDX_W-1:0] LAST_C  = IDX_W'(DEPTH - 1);

   logic [4:0]       state_ff, state_in, ret_ff, ret_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             prep_ff, prep_in;
   logic [IDX_W-1:0] s_ff, s_in, l_ff, l_in, r_ff, r_in;
   logic [IDX_W-1:0] i_ff, i_in, j_ff, j_in;
   logic [IDX_W-1:0] lo_ff, lo_in, hi_ff, hi_in;
   logic [IDX_W-1:0] sa_ff, sa_in, sb_ff, sb_in;
   logic [VAL_W-1:0] lov_ff, lov_in, hiv_ff, hiv_in, piv_ff, piv_in, ta_ff, ta_in;
   logic             rvalid_ff, rvalid_in, rerr_ff, rerr_in;
   logic [VAL_W-1:0] rval_ff, rval_in, res_ff, res_in;
   logic             reserr_ff, reserr_in;
   logic [CNT_W-1:0] n_used;
   logic [IDX_W-1:0] n_last;
   logic [VAL_W-1:0] cmp_a, cmp_b;
   logic             cmp_lt;

   always_comb begin
      if (count_ff == '0) begin
         n_used = CNT_W'(1);
      end else if (count_ff > DEPTH_C) begin
         n_used = DEPTH_C;
      end else begin
         n_used = count_ff;
      end
   end
   assign n_last = IDX_W'(n_used - CNT_W'(1));

   // the one comparator, operands steered by state
   always_comb begin
      case (state_ff)
         ST_SCAN_CK: begin
            cmp_a = elem_rdata;
            cmp_b = lov_ff;
         end
         ST_SCAN_HI: begin
            cmp_a = hiv_ff;
            cmp_b = ta_ff;
         end
         default: begin
            cmp_a = elem_rdata;
            cmp_b = piv_ff;
         end
      endcase
   end
   assign cmp_lt = $signed(cmp_a) < $signed(cmp_b);

   always_comb begin
      state_in  = state_ff;
      ret_in    = ret_ff;
      count_in  = count_ff;
      prep_in   = prep_ff;
      s_in      = s_ff;
      l_in      = l_ff;
      r_in      = r_ff;
      i_in      = i_ff;
      j_in      = j_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      sa_in     = sa_ff;
      sb_in     = sb_ff;
      lov_in    = lov_ff;
      hiv_in    = hiv_ff;
      piv_in    = piv_ff;
      ta_in     = ta_ff;
      rvalid_in = rvalid_ff;
      rval_in   = rval_ff;
      rerr_in   = rerr_ff;
      res_in    = res_ff;
      reserr_in = reserr_ff;
      elem_req  = '{we: 1'b0, addr: i_ff, wdata: '0};
      mark_req  = '{we: 1'b0, addr: i_ff, wdata: 1'b0};

      if (rvalid_ff && rsp_chan.ready) begin
         rvalid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               case (req_chan.operation)
                  OP_WRITE: begin
                     elem_req = '{we: 1'b1, addr: req_chan.slot_index,
                                  wdata: req_chan.element_value};
                     prep_in  = 1'b0;
                  end
                  OP_PREPARE: begin
                     i_in     = '0;
                     state_in = ST_SCAN_RD;
                  end
                  OP_SELECT: begin
                     if (!prep_ff || {1'b0, req_chan.slot_index} >= n_used) begin
                        res_in    = '0;
                        reserr_in = 1'b1;
                        state_in  = ST_RESP;
                     end else begin
                        s_in     = req_chan.slot_index;
                        l_in     = req_chan.slot_index;
                        r_in     = req_chan.slot_index;
                        state_in = ST_SEL_MRD;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SCAN_RD: begin
            elem_req.addr = i_ff;
            state_in      = ST_SCAN_CK;
         end
         ST_SCAN_CK: begin
            ta_in = elem_rdata;
            if (i_ff == '0) begin
               lo_in  = '0;
               hi_in  = '0;
               lov_in = elem_rdata;
               hiv_in = elem_rdata;
            end else if (cmp_lt) begin
               lo_in  = i_ff;
               lov_in = elem_rdata;
            end
            state_in = ST_SCAN_HI;
         end
         ST_SCAN_HI: begin
            if (i_ff != '0 && cmp_lt) begin
               hi_in  = i_ff;
               hiv_in = ta_ff;
            end
            if (i_ff == n_last) begin
               sa_in    = '0;
               sb_in    = lo_ff;
               ret_in   = ST_PREP2;
               state_in = ST_SW_RA;
            end else begin
               i_in     = i_ff + IDX_W'(1);
               state_in = ST_SCAN_RD;
            end
         end
         ST_PREP2: begin
            // the minimum swap has moved a maximum found in slot 0
            sa_in    = n_last;
            sb_in    = (hi_ff == '0) ? lo_ff : hi_ff;
            i_in     = '0;
            ret_in   = ST_CLR;
            state_in = ST_SW_RA;
         end
         ST_CLR: begin
            mark_req = '{we: 1'b1, addr: i_ff, wdata: 1'b0};
            i_in     = i_ff + IDX_W'(1);
            if (i_ff == LAST_C) begin
               state_in = ST_MARK0;
            end
         end
         ST_MARK0: begin
            mark_req = '{we: 1'b1, addr: '0, wdata: 1'b1};
            state_in = ST_MARKN;
         end
         ST_MARKN: begin
            mark_req = '{we: 1'b1, addr: n_last, wdata: 1'b1};
            prep_in  = 1'b1;
            state_in = ST_IDLE;
         end
         ST_SW_RA: begin
            elem_req.addr = sa_ff;
            state_in      = ST_SW_RB;
         end
         ST_SW_RB: begin
            elem_req.addr = sb_ff;
            ta_in         = elem_rdata;
            state_in      = ST_SW_WA;
         end
         ST_SW_WA: begin
            elem_req = '{we: 1'b1, addr: sa_ff, wdata: elem_rdata};
            state_in = ST_SW_WB;
         end
         ST_SW_WB: begin
            elem_req = '{we: 1'b1, addr: sb_ff, wdata: ta_ff};
            state_in = ret_ff;
         end
         ST_SEL_MRD: begin
            mark_req.addr = s_ff;
            state_in      = ST_SEL_MCK;
         end
         ST_SEL_MCK: begin
            if (mark_rdata) begin
               elem_req.addr = s_ff;
               state_in      = ST_SEL_VAL;
            end else begin
               state_in = ST_LSCAN;
            end
         end
         ST_LSCAN: begin
            if (l_ff == '0) begin
               state_in = ST_RSCAN;
            end else begin
               mark_req.addr = l_ff - IDX_W'(1);
               state_in      = ST_LCK;
            end
         end
         ST_LCK: begin
            if (!mark_rdata) begin
               l_in     = l_ff - IDX_W'(1);
               state_in = ST_LSCAN;
            end else begin
               state_in = ST_RSCAN;
            end
         end
         ST_RSCAN: begin
            if ({1'b0, r_ff} + CNT_W'(1) >= n_used) begin
               state_in = ST_LOOP;
            end else begin
               mark_req.addr = r_ff + IDX_W'(1);
               state_in      = ST_RCK;
            end
         end
         ST_RCK: begin
            if (!mark_rdata) begin
               r_in     = r_ff + IDX_W'(1);
               state_in = ST_RSCAN;
            end else begin
               state_in = ST_LOOP;
            end
         end
         ST_LOOP: begin
            if (l_ff >= r_ff) begin
               mark_req      = '{we: 1'b1, addr: s_ff, wdata: 1'b1};
               elem_req.addr = s_ff;
               state_in      = ST_SEL_VAL;
            end else begin
               elem_req.addr = r_ff;
               state_in      = ST_PIV;
            end
         end
         ST_PIV: begin
            piv_in   = elem_rdata;
            i_in     = l_ff;
            j_in     = l_ff;
            state_in = ST_PJ;
         end
         ST_PJ: begin
            if (j_ff < r_ff) begin
               elem_req.addr = j_ff;
               state_in      = ST_PCK;
            end else begin
               sa_in    = i_ff;
               sb_in    = r_ff;
               ret_in   = ST_PEND;
               state_in = ST_SW_RA;
            end
         end
         ST_PCK: begin
            if (cmp_lt) begin
               sa_in    = i_ff;
               sb_in    = j_ff;
               ret_in   = ST_PINC;
               state_in = ST_SW_RA;
            end else begin
               j_in     = j_ff + IDX_W'(1);
               state_in = ST_PJ;
            end
         end
         ST_PINC: begin
            i_in     = i_ff + IDX_W'(1);
            j_in     = j_ff + IDX_W'(1);
            state_in = ST_PJ;
         end
         ST_PEND: begin
            mark_req = '{we: 1'b1, addr: i_ff, wdata: 1'b1};
            if (s_ff == i_ff) begin
               elem_req.addr = i_ff;
               state_in      = ST_SEL_VAL;
            end else begin
               if (s_ff < i_ff) begin
                  r_in = i_ff - IDX_W'(1);
               end else begin
                  l_in = i_ff + IDX_W'(1);
               end
               state_in = ST_LOOP;
            end
         end
         ST_SEL_VAL: begin
            res_in    = elem_rdata;
            reserr_in = 1'b0;
            state_in  = ST_RESP;
         end
         ST_RESP: begin
            // hold until the output register is free
            if (!rvalid_ff || rsp_chan.ready) begin
               rvalid_in = 1'b1;
               rval_in   = res_ff;
               rerr_in   = reserr_ff;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (csr_we) begin
         count_in = csr_wdata;
         prep_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         ret_ff    <= ST_IDLE;
         count_ff  <= DEPTH_C;
         prep_ff   <= 1'b0;
         rvalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         ret_ff    <= ret_in;
         count_ff  <= count_in;
         prep_ff   <= prep_in;
         rvalid_ff <= rvalid_in;
      end
      s_ff      <= s_in;
      l_ff      <= l_in;
      r_ff      <= r_in;
      i_ff      <= i_in;
      j_ff      <= j_in;
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      sa_ff     <= sa_in;
      sb_ff     <= sb_in;
      lov_ff    <= lov_in;
      hiv_ff    <= hiv_in;
      piv_ff    <= piv_in;
      ta_ff     <= ta_in;
      rval_ff   <= rval_in;
      rerr_ff   <= rerr_in;
      res_ff    <= res_in;
      reserr_ff <= reserr_in;
   end

   assign req_chan.ready          = (state_ff == ST_IDLE);
   assign rsp_chan.valid          = rvalid_ff;
   assign rsp_chan.selected_value = rval_ff;
   assign rsp_chan.error          = rerr_ff;
   assign status.busy             = (state_ff != ST_IDLE);
   assign status.prepared         = prep_ff;

endmodule

// ----- rtl/online_quickselect_with_pivot_marks.sv -----
// ----------------------------------------------------------------------------
// online_quickselect_with_pivot_marks: order-statistic store with pivot marks
// A write goes straight to the element memory, starts no job and clears the
// prepared flag. A prepare scans the first n slots for the minimum and
// maximum, swaps them into slot 0 and slot n-1, clears every mark and marks
// both ends. A select on a marked slot reads its value directly; otherwise
// it walks to the bounding marks, then partitions until the slot is marked,
// using the single-port element memory and the one shared signed comparator.
// Requests are refused while a job runs; a finished result waits in a register.
// ----------------------------------------------------------------------------
module online_quickselect_with_pivot_marks import oqs_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_we,
   input  logic [CNT_W-1:0] csr_wdata,
   oqs_req_if.sink          req_chan,
   oqs_rsp_if.source        rsp_chan
);

   elem_req_type     elem_req;
   mark_req_type     mark_req;
   logic [VAL_W-1:0] elem_rdata;
   logic             mark_rdata;
   status_type       status;

   oqs_ram #(.WIDTH(VAL_W), .ADDR_W(IDX_W)) u_elem_ram (
      .clock    (clock),
      .we       (elem_req.we),
      .addr     (elem_req.addr),
      .wdata    (elem_req.wdata),
      .rdata_ff (elem_rdata)
   );

   oqs_ram #(.WIDTH(1), .ADDR_W(IDX_W)) u_mark_ram (
      .clock    (clock),
      .we       (mark_req.we),
      .addr     (mark_req.addr),
      .wdata    (mark_req.wdata),
      .rdata_ff (mark_rdata)
   );

   oqs_core u_core (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_chan   (req_chan),
      .rsp_chan   (rsp_chan),
      .elem_req   (elem_req),
      .elem_rdata (elem_rdata),
      .mark_req   (mark_req),
      .mark_rdata (mark_rdata),
      .status     (status)
   );

`ifndef SYNTHESIS
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.error |-> rsp_chan.selected_value == '0)
      else $error("error result carries a nonzero value");

   a_csr_unprep: assert property (@(posedge clock) disable iff (reset)
      csr_we |=> !status.prepared)
      else $error("count write left the store prepared");

   a_select_busy: assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready && req_chan.operation == OP_SELECT
      |=> status.busy)
      else $error("select transfer did not start a job");
`endif

endmodule
